// ===== rtl/data_island_packet_encoder_macros.svh =====
// ----------------------------------------------------------------------------
// data island packet encoder assertion macros
// shared assertion shorthands, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef DATA_ISLAND_PACKET_ENCODER_MACROS_SVH
`define DATA_ISLAND_PACKET_ENCODER_MACROS_SVH

// same-cycle implication
`define DIPE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dipe assertion failed");

// next-cycle implication
`define DIPE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dipe assertion failed");

`endif

// ===== rtl/dipe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dipe_pkg
// types, constants and the bch parity byte function of the packet encoder
// ----------------------------------------------------------------------------
package dipe_pkg;

  localparam int unsigned SUBPACKETS  = 4;
  localparam int unsigned HDR_BYTES   = 3;
  localparam int unsigned SUB_BYTES   = 7;
  localparam int unsigned PIXELS      = 32;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [4:0] LAST_PIXEL = 5'(PIXELS - 1);
  localparam logic [2:0] LAST_HDR_BYTE = 3'(HDR_BYTES - 1);
  localparam logic [2:0] LAST_SUB_BYTE = 3'(SUB_BYTES - 1);

  // one packet with parity bytes appended, byte n at bits 8n+7..8n
  typedef struct packed {
    logic [SUBPACKETS-1:0][63:0] sub;
    logic [31:0]                 hdr;
    logic                        hsync;
    logic                        vsync;
    logic                        first;
  } pkt_t;

  // eight lfsr steps, generator x^8+x^7+x^6+1, lsb first, state cleared
  function automatic logic [7:0] bch_byte(input logic [7:0] din);
    logic [7:0] st;
    logic [7:0] v;
    logic       fb;
    st = '0;
    v  = din;
    for (int n = 0; n < 8; n++) begin
      fb = st[0] ^ v[0];
      st = {fb, st[7:3], st[2] ^ fb, st[1] ^ fb};
      v  = v >> 1;
    end
    return st;
  endfunction

endpackage

// ===== rtl/dipe_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dipe_front
// accepts a packet and builds the header and subpacket parity one byte a cycle
// ----------------------------------------------------------------------------
module dipe_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [23:0]         in_header_bytes,
  input  logic [55:0]         in_subpacket_0,
  input  logic [55:0]         in_subpacket_1,
  input  logic [55:0]         in_subpacket_2,
  input  logic [55:0]         in_subpacket_3,
  input  logic                in_hsync_level,
  input  logic                in_vsync_level,
  input  logic                in_first_in_island,
  output logic                push,
  output dipe_pkg::pkt_t      push_pkt,
  input  logic                q_full
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CALC = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0]  state_r, state_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [23:0] hdr_r;
  logic [dipe_pkg::SUBPACKETS-1:0][55:0] sub_r;
  logic [7:0]  hpar_r, hpar_nxt;
  logic [dipe_pkg::SUBPACKETS-1:0][7:0] spar_r, spar_nxt;
  logic        hs_r, vs_r, first_r;
  logic        accept;

  assign in_stall = (state_r == ST_CALC) || ((state_r == ST_HOLD) && q_full);
  assign accept   = in_valid && !in_stall;
  assign push     = (state_r == ST_HOLD) && !q_full;

  always_comb begin
    for (int i = 0; i < dipe_pkg::SUBPACKETS; i++) begin
      push_pkt.sub[i] = {spar_r[i], sub_r[i]};
    end
    push_pkt.hdr   = {hpar_r, hdr_r};
    push_pkt.hsync = hs_r;
    push_pkt.vsync = vs_r;
    push_pkt.first = first_r;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    hpar_nxt  = hpar_r;
    spar_nxt  = spar_r;
    unique case (state_r)
      ST_CALC: begin
        for (int i = 0; i < dipe_pkg::SUBPACKETS; i++) begin
          spar_nxt[i] = dipe_pkg::bch_byte(sub_r[i][{cnt_r, 3'b000} +: 8] ^ spar_r[i]);
        end
        if (cnt_r <= dipe_pkg::LAST_HDR_BYTE) begin
          hpar_nxt = dipe_pkg::bch_byte(hdr_r[{cnt_r[1:0], 3'b000} +: 8] ^ hpar_r);
        end
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == dipe_pkg::LAST_SUB_BYTE) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (push) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
      end
    endcase
    if (accept) begin
      state_nxt = ST_CALC;
      cnt_nxt   = '0;
      hpar_nxt  = '0;
      spar_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hpar_r <= hpar_nxt;
    spar_r <= spar_nxt;
    if (accept) begin
      hdr_r    <= in_header_bytes;
      sub_r[0] <= in_subpacket_0;
      sub_r[1] <= in_subpacket_1;
      sub_r[2] <= in_subpacket_2;
      sub_r[3] <= in_subpacket_3;
      hs_r     <= in_hsync_level;
      vs_r     <= in_vsync_level;
      first_r  <= in_first_in_island;
    end
  end

endmodule

// ===== rtl/dipe_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dipe_queue
// small fifo of finished packets between the parity front and the serializer
// ----------------------------------------------------------------------------
module dipe_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  dipe_pkg::pkt_t push_pkt,
  output logic           full,
  input  logic           pop,
  output logic           q_valid,
  output dipe_pkg::pkt_t q_pkt
);

  localparam int unsigned PTR_W = $clog2(dipe_pkg::QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(dipe_pkg::QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(dipe_pkg::QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_C  = PTR_W'(dipe_pkg::QUEUE_DEPTH - 1);

  dipe_pkg::pkt_t   ent_r [dipe_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == DEPTH_C);
  assign q_valid = (cnt_r != '0);
  assign q_pkt   = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_C) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_C) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_pkt;
    end
  end

endmodule

// ===== rtl/dipe_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dipe_back
// walks a queued packet out as 32 pixels of three nibbles, registered output
// ----------------------------------------------------------------------------
`include "data_island_packet_encoder_macros.svh"

module dipe_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  dipe_pkg::pkt_t q_pkt,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [3:0]     out_lane0_nibble,
  output logic [3:0]     out_lane1_nibble,
  output logic [3:0]     out_lane2_nibble,
  output logic           out_last_pixel
);

  dipe_pkg::pkt_t pkt_r;
  logic       act_r, act_nxt;
  logic [4:0] pix_r, pix_nxt;
  logic       out_valid_r;
  logic [3:0] l0_r, l1_r, l2_r;
  logic       out_last_r;
  logic       adv, emit, done;
  logic [3:0] l0_nxt, l1_nxt, l2_nxt;

  assign adv  = !out_valid_r || !out_stall;
  assign emit = adv && act_r;
  assign done = emit && (pix_r == dipe_pkg::LAST_PIXEL);
  assign pop  = q_valid && (!act_r || done);

  always_comb begin
    l0_nxt[0] = pkt_r.hsync;
    l0_nxt[1] = pkt_r.vsync;
    l0_nxt[2] = pkt_r.hdr[pix_r];
    l0_nxt[3] = !((pix_r == '0) && pkt_r.first);
    for (int i = 0; i < dipe_pkg::SUBPACKETS; i++) begin
      l1_nxt[i] = pkt_r.sub[i][{pix_r, 1'b0}];
      l2_nxt[i] = pkt_r.sub[i][{pix_r, 1'b1}];
    end
  end

  always_comb begin
    act_nxt = act_r;
    pix_nxt = pix_r;
    if (emit) begin
      pix_nxt = pix_r + 5'd1;
    end
    if (done) begin
      act_nxt = 1'b0;
    end
    if (pop) begin
      act_nxt = 1'b1;
      pix_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r       <= 1'b0;
      pix_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      act_r <= act_nxt;
      pix_r <= pix_nxt;
      if (adv) begin
        out_valid_r <= act_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      pkt_r <= q_pkt;
    end
    if (emit) begin
      l0_r       <= l0_nxt;
      l1_r       <= l1_nxt;
      l2_r       <= l2_nxt;
      out_last_r <= (pix_r == dipe_pkg::LAST_PIXEL);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_lane0_nibble = l0_r;
  assign out_lane1_nibble = l1_r;
  assign out_lane2_nibble = l2_r;
  assign out_last_pixel   = out_last_r;

  // an idle serializer always sits at pixel zero
  `DIPE_ASSERT_NOW(a_idle_at_zero, !act_r, pix_r == '0)
  // the final pixel of a packet shows up flagged as last
  `DIPE_ASSERT_NEXT(a_last_flag, done, out_valid_r && out_last_r)
  // no bubble inside a packet once a pixel is taken
  `DIPE_ASSERT_NEXT(a_no_gap, out_valid_r && !out_last_r && !out_stall, out_valid_r)

endmodule

// ===== rtl/data_island_packet_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// data_island_packet_encoder
// bch-protected data island packet to per-pixel nibble serializer
// ----------------------------------------------------------------------------
// One input transaction carries a whole packet (three header bytes, four
// seven-byte subpackets, sync levels, first-packet flag). The block appends a
// bch parity byte to the header and to each subpacket and then produces 32
// output transactions, one per pixel, pixel 0 first, with last_pixel set on
// the 32nd. A steady stream runs at the pace set by the pixel serializer. The
// front computes parity one byte a cycle and parks finished packets in a
// two-entry queue, so it takes the next packet while the serializer is still
// busy; a packet passes through the front, the queue and the serializer's
// output register before its first pixel appears. No configuration and no
// state survives between packets.
// ----------------------------------------------------------------------------
module data_island_packet_encoder (
  input  logic        clk,
  input  logic        rst_n,
  // input channel, one transaction per packet
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [23:0] in_header_bytes,
  input  logic [55:0] in_subpacket_0,
  input  logic [55:0] in_subpacket_1,
  input  logic [55:0] in_subpacket_2,
  input  logic [55:0] in_subpacket_3,
  input  logic        in_hsync_level,
  input  logic        in_vsync_level,
  input  logic        in_first_in_island,
  // result channel, one transaction per pixel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_lane0_nibble,
  output logic [3:0]  out_lane1_nibble,
  output logic [3:0]  out_lane2_nibble,
  output logic        out_last_pixel
);

  // front to queue
  logic           push;
  dipe_pkg::pkt_t push_pkt;
  logic           q_full;

  // queue to serializer
  logic           q_valid;
  dipe_pkg::pkt_t q_pkt;
  logic           pop;

  // parity front: byte-serial bch over header and all subpackets in parallel
  dipe_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_header_bytes    (in_header_bytes),
    .in_subpacket_0     (in_subpacket_0),
    .in_subpacket_1     (in_subpacket_1),
    .in_subpacket_2     (in_subpacket_2),
    .in_subpacket_3     (in_subpacket_3),
    .in_hsync_level     (in_hsync_level),
    .in_vsync_level     (in_vsync_level),
    .in_first_in_island (in_first_in_island),
    .push               (push),
    .push_pkt           (push_pkt),
    .q_full             (q_full)
  );

  // decoupling queue of finished packets
  dipe_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_pkt (push_pkt),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_pkt    (q_pkt)
  );

  // pixel serializer with output register
  dipe_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_pkt            (q_pkt),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_lane0_nibble (out_lane0_nibble),
    .out_lane1_nibble (out_lane1_nibble),
    .out_lane2_nibble (out_lane2_nibble),
    .out_last_pixel   (out_last_pixel)
  );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the data island packet encoder
// ----------------------------------------------------------------------------
// Drives whole packets into the encoder and checks every pixel transaction
// that comes out. Each accepted packet is expanded into its 32 expected
// pixels: the bench recomputes the bch parity bytes, splits the bits over the
// three lanes and queues the pixels in order. Any pixel that arrives with
// nothing pending, or with a wrong field, is an error. A short directed table
// is driven first: zero packets have their pixels typed in, all other rows
// use the predictor. Random packets follow. Both sides idle in random bursts,
// and the last part of the run has no idling at all.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int          RANDOM_PACKETS = 420;
  localparam int          DIRECTED_ROWS  = 16;
  localparam int          QUIET_TAIL     = 60;     // last packets with no idling
  localparam int          DRAIN_CYCLES   = 40;     // well past the encoder's latency
  localparam int          CYCLE_LIMIT    = 1000000;
  localparam logic [7:0]  BCH_TAPS       = 8'h83;  // x^8+x^7+x^6+1, shifting right
  localparam logic [55:0] ZERO56         = '0;
  localparam logic [55:0] ONES56         = '1;

  // one input transaction, as driven on the in_ ports
  typedef struct packed {
    logic [23:0] hdr;
    logic [55:0] sub0;
    logic [55:0] sub1;
    logic [55:0] sub2;
    logic [55:0] sub3;
    logic        hs;
    logic        vs;
    logic        first;
  } packet_t;

  // one output transaction
  typedef struct packed {
    logic [3:0] lane0;
    logic [3:0] lane1;
    logic [3:0] lane2;
    logic       last;
  } pixel_t;

  // directed row; zero-data rows carry their lane0 nibbles typed in
  typedef struct packed {
    packet_t    pkt;
    logic       fixed_exp;
    logic [3:0] lane0_pix0;
    logic [3:0] lane0_rest;
  } directed_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [23:0] in_header_bytes = '0;
  logic [55:0] in_subpacket_0 = '0;
  logic [55:0] in_subpacket_1 = '0;
  logic [55:0] in_subpacket_2 = '0;
  logic [55:0] in_subpacket_3 = '0;
  logic        in_hsync_level = 1'b0;
  logic        in_vsync_level = 1'b0;
  logic        in_first_in_island = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  out_lane0_nibble;
  logic [3:0]  out_lane1_nibble;
  logic [3:0]  out_lane2_nibble;
  logic        out_last_pixel;

  pixel_t pending_pixels [$];   // expected pixels, oldest first
  int     error_count = 0;
  int     cycle_count = 0;
  int     idle_mode = 0;        // 0 none, 1 light, 2 heavy; shared by both sides
  int     stall_hold = 0;

  directed_row_t directed [DIRECTED_ROWS] = '{
    // all-zero data: parity is zero, so only sync and marker bits show up
    '{'{24'h0, ZERO56, ZERO56, ZERO56, ZERO56, 1'b0, 1'b0, 1'b1}, 1'b1, 4'h0, 4'h8},
    '{'{24'h0, ZERO56, ZERO56, ZERO56, ZERO56, 1'b1, 1'b0, 1'b0}, 1'b1, 4'h9, 4'h9},
    '{'{24'h0, ZERO56, ZERO56, ZERO56, ZERO56, 1'b0, 1'b1, 1'b1}, 1'b1, 4'h2, 4'hA},
    '{'{24'h0, ZERO56, ZERO56, ZERO56, ZERO56, 1'b1, 1'b1, 1'b0}, 1'b1, 4'hB, 4'hB},
    '{'{24'h0, ZERO56, ZERO56, ZERO56, ZERO56, 1'b1, 1'b1, 1'b1}, 1'b1, 4'h3, 4'hB},
    // every bit set, with and without the first-packet flag
    '{'{24'hFFFFFF, ONES56, ONES56, ONES56, ONES56, 1'b1, 1'b1, 1'b1}, 1'b0, 4'h0, 4'h0},
    '{'{24'hFFFFFF, ONES56, ONES56, ONES56, ONES56, 1'b0, 1'b0, 1'b0}, 1'b0, 4'h0, 4'h0},
    // header only, then lowest and highest single bits
    '{'{24'hFFFFFF, ZERO56, ZERO56, ZERO56, ZERO56, 1'b1, 1'b0, 1'b0}, 1'b0, 4'h0, 4'h0},
    '{'{24'h000001, 56'h1, 56'h2, 56'h4, 56'h8, 1'b0, 1'b1, 1'b1}, 1'b0, 4'h0, 4'h0},
    '{'{24'h800000, 56'h80_0000_0000_0000, 56'h80_0000_0000_0000,
        56'h80_0000_0000_0000, 56'h80_0000_0000_0000, 1'b0, 1'b0, 1'b0},
      1'b0, 4'h0, 4'h0},
    // alternating bits land all on one lane, then all on the other
    '{'{24'h555555, 56'h55_5555_5555_5555, 56'h55_5555_5555_5555,
        56'h55_5555_5555_5555, 56'h55_5555_5555_5555, 1'b1, 1'b0, 1'b1},
      1'b0, 4'h0, 4'h0},
    '{'{24'hAAAAAA, 56'hAA_AAAA_AAAA_AAAA, 56'hAA_AAAA_AAAA_AAAA,
        56'hAA_AAAA_AAAA_AAAA, 56'hAA_AAAA_AAAA_AAAA, 1'b0, 1'b1, 1'b0},
      1'b0, 4'h0, 4'h0},
    // one subpacket lit at a time shows up in one bit of each lane
    '{'{24'h0, ONES56, ZERO56, ZERO56, ZERO56, 1'b0, 1'b0, 1'b0}, 1'b0, 4'h0, 4'h0},
    '{'{24'h0, ZERO56, ZERO56, ZERO56, ONES56, 1'b1, 1'b1, 1'b0}, 1'b0, 4'h0, 4'h0},
    // counting bytes catch byte order mistakes
    '{'{24'h030201, 56'h07_0605_0403_0201, 56'h17_1615_1413_1211,
        56'h27_2625_2423_2221, 56'h37_3635_3433_3231, 1'b1, 1'b1, 1'b0},
      1'b0, 4'h0, 4'h0},
    '{'{24'h010000, ZERO56, 56'h01_0000_0000_0000, ZERO56, ZERO56, 1'b0, 1'b0, 1'b1},
      1'b0, 4'h0, 4'h0}
  };

  data_island_packet_encoder DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_header_bytes    (in_header_bytes),
    .in_subpacket_0     (in_subpacket_0),
    .in_subpacket_1     (in_subpacket_1),
    .in_subpacket_2     (in_subpacket_2),
    .in_subpacket_3     (in_subpacket_3),
    .in_hsync_level     (in_hsync_level),
    .in_vsync_level     (in_vsync_level),
    .in_first_in_island (in_first_in_island),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_lane0_nibble   (out_lane0_nibble),
    .out_lane1_nibble   (out_lane1_nibble),
    .out_lane2_nibble   (out_lane2_nibble),
    .out_last_pixel     (out_last_pixel)
  );

  always #2 clk = ~clk;

  // folds one data byte into the running bch parity of a block; the byte is
  // mixed with the parity so far and shifted through a cleared register
  function automatic logic [7:0] bch_fold(input logic [7:0] acc, input logic [7:0] data_byte);
    logic [7:0] v;
    logic [7:0] r;
    logic       fb;
    v = acc ^ data_byte;
    r = '0;
    for (int b = 0; b < 8; b++) begin
      fb = r[0] ^ v[b];
      r  = (r >> 1) ^ ({8{fb}} & BCH_TAPS);
    end
    return r;
  endfunction

  // expands one accepted packet into its 32 pixels and queues them
  function automatic void queue_packet_pixels(input packet_t pk);
    logic [7:0]  hdr [4];
    logic [7:0]  sub [4][8];
    logic [55:0] words [4];
    logic [7:0]  acc;
    pixel_t      px;
    words = '{pk.sub0, pk.sub1, pk.sub2, pk.sub3};
    acc = '0;
    for (int n = 0; n < 3; n++) begin
      hdr[n] = pk.hdr[8*n +: 8];
      acc    = bch_fold(acc, hdr[n]);
    end
    hdr[3] = acc;
    for (int i = 0; i < 4; i++) begin
      acc = '0;
      for (int n = 0; n < 7; n++) begin
        sub[i][n] = words[i][8*n +: 8];
        acc       = bch_fold(acc, sub[i][n]);
      end
      sub[i][7] = acc;
    end
    for (int p = 0; p < dipe_pkg::PIXELS; p++) begin
      // marker drops only on pixel 0 of the first packet of an island
      px.lane0 = {(p == 0 && pk.first) ? 1'b0 : 1'b1, hdr[p/8][p%8], pk.vs, pk.hs};
      for (int i = 0; i < 4; i++) begin
        px.lane1[i] = sub[i][p/4][2*(p%4)];
        px.lane2[i] = sub[i][p/4][2*(p%4)+1];
      end
      px.last = (p == dipe_pkg::PIXELS - 1);
      pending_pixels.push_back(px);
    end
  endfunction

  // run limit, sized far above the slowest legal run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // result side: check each accepted pixel transaction, then pick the next
  // stall value; stalls come in random bursts
  always @(posedge clk) begin : pixel_check
    pixel_t want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        $error("pixel transaction with nothing pending");
        error_count++;
      end else begin
        want = pending_pixels.pop_front();
        if (out_lane0_nibble !== want.lane0) begin
          $error("lane0_nibble expected %h got %h", want.lane0, out_lane0_nibble);
          error_count++;
        end
        if (out_lane1_nibble !== want.lane1) begin
          $error("lane1_nibble expected %h got %h", want.lane1, out_lane1_nibble);
          error_count++;
        end
        if (out_lane2_nibble !== want.lane2) begin
          $error("lane2_nibble expected %h got %h", want.lane2, out_lane2_nibble);
          error_count++;
        end
        if (out_last_pixel !== want.last) begin
          $error("last_pixel expected %b got %b", want.last, out_last_pixel);
          error_count++;
        end
      end
    end
    if (stall_hold > 0) begin
      stall_hold--;
      out_stall <= 1'b1;
    end else if (idle_mode != 0 && $urandom_range(0, idle_mode == 1 ? 7 : 1) == 0) begin
      stall_hold = $urandom_range(0, 7);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // packet side: directed table first, then random packets
  initial begin : stimulus
    packet_t pk;
    pixel_t  px;
    int      total;
    total = DIRECTED_ROWS + RANDOM_PACKETS;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    for (int idx = 0; idx < total; idx++) begin
      // idling level changes every 30 packets, and stops for the tail
      if (idx >= total - QUIET_TAIL)
        idle_mode = 0;
      else if (idx % 30 == 0)
        idle_mode = $urandom_range(0, 2);
      if (idx < DIRECTED_ROWS) begin
        pk = directed[idx].pkt;
      end else begin
        pk.hdr   = 24'($urandom());
        pk.sub0  = 56'({$urandom(), $urandom()});
        pk.sub1  = 56'({$urandom(), $urandom()});
        pk.sub2  = 56'({$urandom(), $urandom()});
        pk.sub3  = 56'({$urandom(), $urandom()});
        pk.hs    = 1'($urandom_range(0, 1));
        pk.vs    = 1'($urandom_range(0, 1));
        pk.first = ($urandom_range(0, 3) == 0);
      end
      if (idle_mode != 0 && $urandom_range(0, idle_mode == 1 ? 7 : 1) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      in_valid           <= 1'b1;
      in_header_bytes    <= pk.hdr;
      in_subpacket_0     <= pk.sub0;
      in_subpacket_1     <= pk.sub1;
      in_subpacket_2     <= pk.sub2;
      in_subpacket_3     <= pk.sub3;
      in_hsync_level     <= pk.hs;
      in_vsync_level     <= pk.vs;
      in_first_in_island <= pk.first;
      @(posedge clk);
      while (in_stall !== 1'b0) @(posedge clk);
      // transaction taken at this edge
      if (idx < DIRECTED_ROWS && directed[idx].fixed_exp) begin
        for (int p = 0; p < dipe_pkg::PIXELS; p++) begin
          px.lane0 = (p == 0) ? directed[idx].lane0_pix0 : directed[idx].lane0_rest;
          px.lane1 = 4'h0;
          px.lane2 = 4'h0;
          px.last  = (p == dipe_pkg::PIXELS - 1);
          pending_pixels.push_back(px);
        end
      end else begin
        queue_packet_pixels(pk);
      end
    end
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    // extra cycles catch stray pixels after the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_pixels.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
